// ===== hw/rtl/sps_pkg.sv =====
// Package for the H.264 SPS size parser: parse phases, status codes and the
// controller/datapath command and status structs. No dependencies.
package sps_pkg;
	localparam logic [4:0] PH_HDR = 5'd0, PH_PROFILE = 5'd1, PH_FLAGS_LEVEL = 5'd2,
		PH_SPS_ID = 5'd3, PH_CHROMA = 5'd4, PH_RESID = 5'd5, PH_DEPTH_LUMA = 5'd6,
		PH_DEPTH_CHROMA = 5'd7, PH_BYPASS_SCALING = 5'd8, PH_LIST_FLAGS = 5'd9,
		PH_LOG2_FRAME = 5'd10, PH_POC_TYPE = 5'd11, PH_POC_LSB = 5'd12,
		PH_DELTA_ZERO = 5'd13, PH_OFF_NONREF = 5'd14, PH_OFF_TOPBOT = 5'd15,
		PH_CYCLE_LEN = 5'd16, PH_OFF_REF = 5'd17, PH_NUM_REF = 5'd18, PH_GAPS = 5'd19,
		PH_WIDTH = 5'd20, PH_HEIGHT = 5'd21, PH_DONE = 5'd22;

	localparam logic [2:0] ST_OK = 3'd0, ST_NOT_SPS = 3'd1, ST_TRUNC = 3'd2,
		ST_TOO_LONG = 3'd3, ST_RANGE = 3'd4;

	localparam logic [7:0] PROF_A = 8'd100, PROF_B = 8'd110, PROF_C = 8'd122,
		PROF_D = 8'd144;

	// Width of a fixed field per phase; zero marks an Exp-Golomb code.
	function automatic logic [5:0] phase_bits(input logic [4:0] ph);
		case (ph)
			PH_HDR, PH_PROFILE, PH_LIST_FLAGS: phase_bits = 6'd8;
			PH_FLAGS_LEVEL: phase_bits = 6'd16;
			PH_RESID, PH_DELTA_ZERO, PH_GAPS: phase_bits = 6'd1;
			PH_BYPASS_SCALING: phase_bits = 6'd2;
			default: phase_bits = 6'd0;
		endcase
	endfunction

	typedef struct packed {
		logic load;   // latch the input byte, start a bit walk
		logic bit_en; // feed the current bit
		logic rearm;  // clear all parse state
	} cmd_t;

	typedef struct packed {
		logic       done;   // a result is known on this bit
		logic [2:0] status;
		logic       last_bit;
	} sts_t;
endpackage

// ===== hw/rtl/sps_datapath.sv =====
// Bit-serial SPS field datapath: shifter, Exp-Golomb decoder, phase walk.
// Depends on sps_pkg.
module sps_datapath #(
	parameter int MAX_MBS = 4096,
	parameter int MAX_REF_CYCLE = 255,
	parameter int MAX_CODE_ZEROS = 31
) (
	input  logic clk,
	input  logic arst_n,
	input  logic [7:0] byte_value,
	input  sps_pkg::cmd_t cmd,
	output sps_pkg::sts_t sts,
	output logic [16:0] width_pixels,
	output logic [16:0] height_pixels
);
	import sps_pkg::*;

	logic [4:0]  phase_q;
	logic [7:0]  byte_q;
	logic [2:0]  bit_q;
	logic [5:0]  zeros_q;
	logic [31:0] acc_q;
	logic [5:0]  left_q;
	logic [7:0]  prof_q;
	logic [7:0]  cyc_q;
	logic [12:0] wmbs_q;
	logic [16:0] wpx_q, hpx_q;

	logic        b;
	logic [31:0] acc_n;
	logic [32:0] v;
	logic        fin;
	logic        fixed;
	logic [4:0]  nph;
	logic        res;
	logic [2:0]  rst_code;
	logic [32:0] vp1;

	assign b = byte_q[3'd7 - bit_q];
	assign fixed = (phase_bits(phase_q) != 6'd0);
	assign acc_n = {acc_q[30:0], b};
	assign vp1 = v + 33'd1;

	always_comb begin
		fin = 1'b0;
		v = 33'd0;
		res = 1'b0;
		rst_code = ST_OK;
		if (phase_q < PH_DONE) begin
			if (fixed) begin
				v = {1'b0, acc_n};
				fin = (left_q == 6'd1);
			end else if (left_q == 6'd0) begin
				if (!b && zeros_q >= 6'(MAX_CODE_ZEROS)) begin
					res = 1'b1;
					rst_code = ST_TOO_LONG;
				end
				fin = b && (zeros_q == 6'd0);
			end else begin
				v = ((33'd1 << zeros_q) - 33'd1) + {1'b0, acc_n};
				fin = (left_q == 6'd1);
			end
		end
		nph = phase_q;
		if (fin) begin
			case (phase_q)
				PH_HDR: begin
					nph = PH_PROFILE;
					if (v[4:0] != 5'd7) begin res = 1'b1; rst_code = ST_NOT_SPS; end
				end
				PH_PROFILE: nph = PH_FLAGS_LEVEL;
				PH_FLAGS_LEVEL: nph = PH_SPS_ID;
				PH_SPS_ID: nph = (prof_q == PROF_A || prof_q == PROF_B ||
					prof_q == PROF_C || prof_q == PROF_D) ? PH_CHROMA : PH_LOG2_FRAME;
				PH_CHROMA: nph = (v == 33'd3) ? PH_RESID : PH_DEPTH_LUMA;
				PH_RESID: nph = PH_DEPTH_LUMA;
				PH_DEPTH_LUMA: nph = PH_DEPTH_CHROMA;
				PH_DEPTH_CHROMA: nph = PH_BYPASS_SCALING;
				PH_BYPASS_SCALING: nph = v[0] ? PH_LIST_FLAGS : PH_LOG2_FRAME;
				PH_LIST_FLAGS: nph = PH_LOG2_FRAME;
				PH_LOG2_FRAME: nph = PH_POC_TYPE;
				PH_POC_TYPE: nph = (v == 33'd0) ? PH_POC_LSB :
					(v == 33'd1) ? PH_DELTA_ZERO : PH_NUM_REF;
				PH_POC_LSB: nph = PH_NUM_REF;
				PH_DELTA_ZERO: nph = PH_OFF_NONREF;
				PH_OFF_NONREF: nph = PH_OFF_TOPBOT;
				PH_OFF_TOPBOT: nph = PH_CYCLE_LEN;
				PH_CYCLE_LEN: begin
					nph = (v == 33'd0) ? PH_NUM_REF : PH_OFF_REF;
					if (v > 33'(MAX_REF_CYCLE)) begin res = 1'b1; rst_code = ST_RANGE; end
				end
				PH_OFF_REF: nph = (cyc_q == 8'd1) ? PH_NUM_REF : PH_OFF_REF;
				PH_NUM_REF: nph = PH_GAPS;
				PH_GAPS: nph = PH_WIDTH;
				PH_WIDTH: begin
					nph = PH_HEIGHT;
					if (vp1 > 33'(MAX_MBS)) begin res = 1'b1; rst_code = ST_RANGE; end
				end
				PH_HEIGHT: begin
					res = 1'b1;
					rst_code = (vp1 > 33'(MAX_MBS)) ? ST_RANGE : ST_OK;
				end
				default: nph = phase_q;
			endcase
		end
	end

	assign sts.done = cmd.bit_en && res;
	assign sts.status = rst_code;
	assign sts.last_bit = (bit_q == 3'd7);
	assign width_pixels = wpx_q;
	assign height_pixels = hpx_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_HDR; byte_q <= '0; bit_q <= '0; zeros_q <= '0;
			acc_q <= '0; left_q <= phase_bits(PH_HDR); prof_q <= '0;
			cyc_q <= '0; wmbs_q <= '0;
		end else if (cmd.rearm) begin
			phase_q <= PH_HDR; bit_q <= '0; zeros_q <= '0; acc_q <= '0;
			left_q <= phase_bits(PH_HDR); prof_q <= '0; cyc_q <= '0; wmbs_q <= '0;
		end else if (cmd.load) begin
			byte_q <= byte_value;
			bit_q <= '0;
		end else if (cmd.bit_en) begin
			bit_q <= bit_q + 3'd1;
			if (res) begin
				phase_q <= PH_DONE;
				left_q <= '0; zeros_q <= '0; acc_q <= '0;
			end else if (fin) begin
				phase_q <= nph;
				left_q <= phase_bits(nph);
				zeros_q <= '0;
				acc_q <= '0;
				if (phase_q == PH_PROFILE) prof_q <= v[7:0];
				if (phase_q == PH_CYCLE_LEN) cyc_q <= v[7:0];
				if (phase_q == PH_OFF_REF) cyc_q <= cyc_q - 8'd1;
				if (phase_q == PH_WIDTH) wmbs_q <= vp1[12:0];
			end else if (phase_q < PH_DONE) begin
				if (fixed || left_q != 6'd0) begin
					acc_q <= acc_n;
					left_q <= left_q - 6'd1;
				end else if (!b) begin
					zeros_q <= zeros_q + 6'd1;
				end else begin
					left_q <= zeros_q;
					acc_q <= '0;
				end
			end
		end
	end

	// Result pixels are captured with the result; zero on any error.
	always_ff @(posedge clk) begin
		if (cmd.bit_en && res) begin
			if (rst_code == ST_OK) begin
				wpx_q <= {wmbs_q, 4'd0};
				hpx_q <= {vp1[12:0], 4'd0};
			end else begin
				wpx_q <= '0;
				hpx_q <= '0;
			end
		end else if (cmd.load) begin
			wpx_q <= '0;
			hpx_q <= '0;
		end
	end
endmodule

// ===== hw/rtl/sps_ctrl.sv =====
// Sequencer for the SPS parser: accepts bytes, steps up to eight bits of each, issues results.
// Depends on sps_pkg.
module sps_ctrl (
	input  logic clk,
	input  logic arst_n,
	input  logic in_fire,
	input  logic last_byte,
	input  logic out_fire,
	input  sps_pkg::sts_t sts,
	output sps_pkg::cmd_t cmd,
	output logic in_ready,
	output logic out_valid,
	output logic [2:0] out_status,
	output logic trunc_sel
);
	import sps_pkg::*;

	localparam logic [1:0] S_IDLE = 2'd0, S_BITS = 2'd1, S_END = 2'd2;

	logic [1:0] state_q;
	logic       last_q;
	logic       given_q;
	logic       ovalid_q;
	logic [2:0] ostat_q;
	logic       trunc_q;

	assign in_ready = (state_q == S_IDLE) && !ovalid_q;
	assign out_valid = ovalid_q;
	assign out_status = ostat_q;
	assign trunc_sel = trunc_q;

	always_comb begin
		cmd.load = in_fire && !given_q;
		cmd.bit_en = (state_q == S_BITS);
		cmd.rearm = (state_q == S_END) || (in_fire && given_q && last_byte);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE; last_q <= 1'b0; given_q <= 1'b0;
			ovalid_q <= 1'b0; ostat_q <= ST_OK; trunc_q <= 1'b0;
		end else begin
			if (out_fire) ovalid_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (in_fire) begin
						last_q <= last_byte;
						if (given_q) begin
							if (last_byte) given_q <= 1'b0;
						end else begin
							state_q <= S_BITS;
						end
					end
				end
				S_BITS: begin
					if (sts.done) begin
						given_q <= 1'b1;
						ovalid_q <= 1'b1;
						ostat_q <= sts.status;
						trunc_q <= 1'b0;
						state_q <= last_q ? S_END : S_IDLE;
					end else if (sts.last_bit) begin
						if (last_q) begin
							ovalid_q <= 1'b1;
							ostat_q <= ST_TRUNC;
							trunc_q <= 1'b1;
							state_q <= S_END;
						end else begin
							state_q <= S_IDLE;
						end
					end
				end
				S_END: begin
					given_q <= 1'b0;
					state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end
endmodule

// ===== hw/rtl/h264_sps_size_parser.sv =====
// Top level of the H.264 SPS size parser: joins sequencer and datapath.
// Depends on sps_pkg, sps_ctrl and sps_datapath.
//
// Usage: feed one NAL unit (start code removed, header byte first) on the s_
// channel, one byte per transfer, with s_tlast on the final byte. At most one
// result per unit leaves on the m_ channel: tdata holds status, width and
// height in pixels (zero unless status is ok).
// Each accepted byte before a result is walked one bit per clock by the datapath shifter.
// s_tready drops while the bits are walked, so the next byte waits until the
// walk ends. A byte that ends the unit also re-arms the parser (state S_END)
// before the next transfer. A result appears in the cycle after the bit that settles it.
// Bytes after a result are taken without a bit walk and dropped until the unit
// ends.
// Reset clears all parse state; the parser waits for a header byte.
// While a result waits on m_tready, s_tready stays low.
module h264_sps_size_parser #(
	parameter int MAX_MBS = 4096,
	parameter int MAX_REF_CYCLE = 255,
	parameter int MAX_CODE_ZEROS = 31
) (
	input  logic clk,
	input  logic arst_n,
	input  logic s_tvalid,
	output logic s_tready,
	input  logic [7:0] s_tdata,   // byte_value[7:0]
	input  logic s_tlast,         // last_byte
	output logic m_tvalid,
	input  logic m_tready,
	output logic [39:0] m_tdata   // status[2:0], width_pixels[19:3], height_pixels[36:20]
);
	import sps_pkg::*;

	cmd_t cmd;
	sts_t sts;
	logic [16:0] wpx, hpx;
	logic [2:0] ostat;
	logic trunc;

	sps_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .in_fire(s_tvalid && s_tready),
		.last_byte(s_tlast), .out_fire(m_tvalid && m_tready), .sts(sts),
		.cmd(cmd), .in_ready(s_tready), .out_valid(m_tvalid),
		.out_status(ostat), .trunc_sel(trunc)
	);

	sps_datapath #(
		.MAX_MBS(MAX_MBS), .MAX_REF_CYCLE(MAX_REF_CYCLE),
		.MAX_CODE_ZEROS(MAX_CODE_ZEROS)
	) u_dp (
		.clk(clk), .arst_n(arst_n), .byte_value(s_tdata), .cmd(cmd), .sts(sts),
		.width_pixels(wpx), .height_pixels(hpx)
	);

	assign m_tdata = {3'd0, trunc ? 17'd0 : hpx, trunc ? 17'd0 : wpx, ostat};

`ifndef SYNTH
	a_no_accept_while_full: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> !s_tready) else $error("input taken while result pending");
	a_ok_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && ostat == ST_OK) |-> (wpx != 17'd0 && hpx != 17'd0))
		else $error("ok result with zero size");
	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && ostat != ST_OK) |-> (m_tdata[36:3] == 34'd0))
		else $error("error result with nonzero size");
`endif
endmodule
